// ===== rtl/core/cup_pkg.sv =====
// shared types, register codes and byte folding for copy_until_pattern
`timescale 1ns / 1ps

package cup_pkg;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int LEN_W      = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_CS = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EVAL   = 4'b0010,
    ST_EMIT   = 4'b0100,
    ST_STATUS = 4'b1000
  } cup_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // append accepted byte to window
    logic eval;   // latch shift amount and match result
    logic shift;  // head byte delivered, drop it
    logic clear;  // status delivered, empty window
  } cup_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic emit_left;
    logic emit_last;
    logic hit;
    logic eos;
  } cup_sts_t;

  // ascii upper-casing unless exact compare
  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic exact);
    logic [7:0] r;
    r = c;
    if (!exact && c >= 8'h61 && c <= 8'h7a) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/copy_until_pattern.sv =====
// top level: copy a byte stream until a configured pattern is found
`timescale 1ns / 1ps

// copy_until_pattern passes bytes from the input channel to the output channel
// until the first occurrence of a pattern of 1 to PATTERN_MAX bytes (exact or
// ascii case-insensitive compare), holding back only bytes that could still
// begin a match. on a match the held bytes are dropped, one found status
// transaction is sent, and input bytes are discarded up to and including the
// end-of-stream byte. if the stream ends first, the held bytes are flushed and
// a not-found status follows. one input transaction at a time: an accepted
// byte is registered into the window, the parallel prefix compare over the
// whole window then latches the copy count and match result, and the result
// transactions follow in turn (an emit step runs even when none is copied);
// bytes discarded after a match are accepted while idle. the output stall
// holds back results. last_of_run marks the final result of each input byte.
// configuration must be written only while idle; the block does not check it.

module copy_until_pattern import cup_pkg::*; #(
  parameter int PATTERN_MAX = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_end_of_stream,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_out_byte,
  output logic                  out_is_status,
  output logic                  out_pattern_found,
  output logic                  out_last_of_run,
  // configuration write port
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

  cup_cmd_t   cmd;   // controller commands
  cup_sts_t   sts;   // datapath status
  logic [7:0] head_byte;

  // controller: owns the handshakes and the discard-after-match flag
  cup_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_eos        (in_end_of_stream),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_is_status (out_is_status),
    .out_found     (out_pattern_found),
    .out_last      (out_last_of_run),
    .sts           (sts),
    .cmd           (cmd)
  );

  // datapath: window shift register, pattern registers, prefix compare
  cup_datapath #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .in_byte     (in_data_byte),
    .in_eos      (in_end_of_stream),
    .cmd         (cmd),
    .sts         (sts),
    .head_byte   (head_byte)
  );

  // copied bytes always come from the front of the window; status carries zero
  assign out_out_byte = out_is_status ? 8'h00 : head_byte;

endmodule

// ===== rtl/core/cup_datapath.sv =====
// window storage, pattern registers and parallel prefix compare
`timescale 1ns / 1ps

module cup_datapath import cup_pkg::*; #(
  parameter int PATTERN_MAX = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  input  logic [7:0]            in_byte,
  input  logic                  in_eos,
  input  cup_cmd_t              cmd,
  output cup_sts_t              sts,
  output logic [7:0]            head_byte
);

  localparam int CW = $clog2(PATTERN_MAX + 1);

  logic [CFG_DATA_W-1:0] pat_lo_r, pat_hi_r;
  logic [LEN_W-1:0]      len_r;
  logic                  exact_r;

  logic [7:0]    win_r   [PATTERN_MAX];
  logic [7:0]    win_nxt [PATTERN_MAX];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] emit_r, emit_nxt;
  logic          hit_r, hit_nxt;
  logic          eos_r, eos_nxt;

  logic [7:0]             wf [PATTERN_MAX];
  logic [7:0]             pf [PATTERN_MAX];
  logic [2*CFG_DATA_W-1:0] pat_all;
  logic [PATTERN_MAX-1:0] cand;
  logic [CW-1:0]          sel, rem, len_eff;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      len_r    <= LEN_W'(1);
      exact_r  <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PAT_LOW:  pat_lo_r <= cfg_wr_data;
        REG_PAT_HIGH: pat_hi_r <= cfg_wr_data;
        REG_PAT_LEN:  len_r    <= cfg_wr_data[LEN_W-1:0];
        REG_MATCH_CS: exact_r  <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  // out-of-range lengths clamp to 1..PATTERN_MAX
  always_comb begin
    if (len_r == '0) begin
      len_eff = CW'(1);
    end else if (len_r > LEN_W'(PATTERN_MAX)) begin
      len_eff = CW'(PATTERN_MAX);
    end else begin
      len_eff = CW'(len_r);
    end
  end

  assign pat_all = {pat_hi_r, pat_lo_r};

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      wf[i] = fold_byte(win_r[i], exact_r);
      pf[i] = fold_byte(pat_all[8*i +: 8], exact_r);
    end
  end

  // candidate start s: tail from s fits and equals a pattern prefix
  always_comb begin
    for (int s = 0; s < PATTERN_MAX; s++) begin
      cand[s] = (CW'(s) < cnt_r) && ((cnt_r - CW'(s)) <= len_eff);
      for (int i = 0; i < PATTERN_MAX - s; i++) begin
        if ((CW'(s + i) < cnt_r) && (wf[s+i] != pf[i])) begin
          cand[s] = 1'b0;
        end
      end
    end
    sel = cnt_r;
    for (int s = PATTERN_MAX - 1; s >= 0; s--) begin
      if (cand[s]) begin
        sel = CW'(s);
      end
    end
    rem = cnt_r - sel;
  end

  always_comb begin
    win_nxt  = win_r;
    cnt_nxt  = cnt_r;
    emit_nxt = emit_r;
    hit_nxt  = hit_r;
    eos_nxt  = eos_r;
    if (cmd.load) begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
        if (CW'(i) == cnt_r) begin
          win_nxt[i] = in_byte;
        end
      end
      cnt_nxt = cnt_r + CW'(1);
      eos_nxt = in_eos;
    end
    if (cmd.eval) begin
      hit_nxt  = (rem == len_eff);
      emit_nxt = (!hit_nxt && eos_r) ? cnt_r : sel;
    end
    if (cmd.shift) begin
      for (int i = 0; i < PATTERN_MAX - 1; i++) begin
        win_nxt[i] = win_r[i+1];
      end
      cnt_nxt  = cnt_r - CW'(1);
      emit_nxt = emit_r - CW'(1);
    end
    if (cmd.clear) begin
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      emit_r <= '0;
      hit_r  <= 1'b0;
      eos_r  <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      emit_r <= emit_nxt;
      hit_r  <= hit_nxt;
      eos_r  <= eos_nxt;
    end
  end

  assign sts.emit_left = (emit_r != '0);
  assign sts.emit_last = (emit_r == CW'(1));
  assign sts.hit       = hit_r;
  assign sts.eos       = eos_r;
  assign head_byte     = win_r[0];

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(PATTERN_MAX))
    else $error("window count above depth");

  a_emit_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    emit_r <= cnt_r)
    else $error("more bytes to copy than held");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> cnt_r == '0)
    else $error("window not empty after status");

endmodule

// ===== rtl/core/cup_ctrl.sv =====
// sequencing state machine for copy_until_pattern
`timescale 1ns / 1ps

module cup_ctrl import cup_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     in_eos,
  output logic     out_valid,
  input  logic     out_stall,
  output logic     out_is_status,
  output logic     out_found,
  output logic     out_last,
  input  cup_sts_t sts,
  output cup_cmd_t cmd
);

  cup_state_t state_r, state_nxt;
  logic       matched_r, matched_nxt;
  logic       in_acc, out_acc, ends;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign ends     = sts.hit || sts.eos;

  assign out_valid     = ((state_r == ST_EMIT) && sts.emit_left) || (state_r == ST_STATUS);
  assign out_is_status = (state_r == ST_STATUS);
  assign out_found     = (state_r == ST_STATUS) && sts.hit;
  assign out_last      = (state_r == ST_STATUS) ||
                         ((state_r == ST_EMIT) && sts.emit_last && !ends);

  always_comb begin
    state_nxt   = state_r;
    matched_nxt = matched_r;
    cmd         = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (matched_r) begin
            if (in_eos) begin
              matched_nxt = 1'b0;
            end
          end else begin
            cmd.load  = 1'b1;
            state_nxt = ST_EVAL;
          end
        end
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts.emit_left) begin
          state_nxt = ends ? ST_STATUS : ST_IDLE;
        end else if (out_acc) begin
          cmd.shift = 1'b1;
          if (sts.emit_last) begin
            state_nxt = ends ? ST_STATUS : ST_IDLE;
          end
        end
      end
      ST_STATUS: begin
        if (out_acc) begin
          cmd.clear   = 1'b1;
          matched_nxt = sts.hit && !sts.eos;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      matched_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      matched_r <= matched_nxt;
    end
  end

  a_matched_idle: assert property (@(posedge clk) disable iff (!rst_n)
    matched_r |-> state_r == ST_IDLE)
    else $error("discard mode outside idle");

  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STATUS) && out_acc |=> state_r == ST_IDLE)
    else $error("status transaction did not finish the run");

  a_one_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_last && !out_is_status |=> state_r == ST_IDLE)
    else $error("run continued after last byte");

endmodule
